FILE: sv/sfp_pkg.sv
// Package for the sync framed packet parser: frame constants, phase codes,
// register indexes and the shared config and result types. No dependencies.
`default_nettype none
package sfp_pkg;

    localparam int unsigned PayloadLen = 9;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned PhaseW     = 4;
    localparam int unsigned CfgIdxW    = 2;

    localparam logic [PhaseW-1:0] PH_HUNT  = 4'd0;
    localparam logic [PhaseW-1:0] PH_HDR2  = 4'd1;
    localparam logic [PhaseW-1:0] PH_PAY0  = 4'd2;
    localparam logic [PhaseW-1:0] PH_PAY8  = 4'd10;
    localparam logic [PhaseW-1:0] PH_TAIL1 = 4'd11;
    localparam logic [PhaseW-1:0] PH_TAIL2 = 4'd12;

    localparam logic [CfgIdxW-1:0] CFG_HEADER = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TAIL1  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TAIL2  = 2'd2;

    localparam logic [ByteW-1:0] HEADER_RST = 8'hB3;
    localparam logic [ByteW-1:0] TAIL1_RST  = 8'h0B;
    localparam logic [ByteW-1:0] TAIL2_RST  = 8'h0A;

    typedef logic [ByteW-1:0] byte_t;

    typedef struct packed {
        byte_t header_byte;
        byte_t first_tail_byte;
        byte_t last_tail_byte;
    } cfg_t;

    typedef struct packed {
        logic                      emit;
        logic                      frame_ok;
        logic [PayloadLen*ByteW-1:0] payload;
    } res_t;

endpackage
`default_nettype wire

FILE: sv/sfp_deframer.sv
// Frame phase counter and payload store; decides the result of each byte.
// Depends on sfp_pkg.
`default_nettype none
module sfp_deframer (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire sfp_pkg::byte_t rx_byte,
    input  wire sfp_pkg::cfg_t cfg,
    output sfp_pkg::res_t      res
);

    logic [sfp_pkg::PhaseW-1:0] phase_reg, phase_next;
    sfp_pkg::byte_t             store_reg [sfp_pkg::PayloadLen];
    logic [sfp_pkg::PhaseW-1:0] wr_idx;
    logic                       wr_en;
    logic                       emit, ok;

    assign wr_idx = phase_reg - sfp_pkg::PH_PAY0;

    always_comb begin
        phase_next = phase_reg;
        wr_en      = 1'b0;
        emit       = 1'b0;
        ok         = 1'b0;
        if (phase_reg == sfp_pkg::PH_HUNT) begin
            if (rx_byte == cfg.header_byte) phase_next = sfp_pkg::PH_HDR2;
        end else if (phase_reg == sfp_pkg::PH_HDR2) begin
            phase_next = (rx_byte == cfg.header_byte) ? sfp_pkg::PH_PAY0 : sfp_pkg::PH_HUNT;
        end else if (phase_reg >= sfp_pkg::PH_PAY0 && phase_reg <= sfp_pkg::PH_PAY8) begin
            wr_en      = 1'b1;
            phase_next = phase_reg + 4'd1;
        end else if (phase_reg == sfp_pkg::PH_TAIL1) begin
            if (rx_byte == cfg.first_tail_byte) begin
                phase_next = sfp_pkg::PH_TAIL2;
            end else begin
                phase_next = sfp_pkg::PH_HUNT;
                emit       = 1'b1;
            end
        end else if (phase_reg == sfp_pkg::PH_TAIL2) begin
            phase_next = sfp_pkg::PH_HUNT;
            emit       = 1'b1;
            ok         = (rx_byte == cfg.last_tail_byte);
        end else begin
            phase_next = sfp_pkg::PH_HUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sfp_pkg::PH_HUNT;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < sfp_pkg::PayloadLen; k++) begin
            if (accept && wr_en && wr_idx == k[sfp_pkg::PhaseW-1:0]) store_reg[k] <= rx_byte;
        end
    end

    always_comb begin
        res.emit     = emit;
        res.frame_ok = ok;
        for (int k = 0; k < sfp_pkg::PayloadLen; k++) begin
            res.payload[k*sfp_pkg::ByteW +: sfp_pkg::ByteW] = ok ? store_reg[k] : '0;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sfp_out_reg.sv
// Result register of the parser: holds one result item until taken.
// Depends on sfp_pkg.
`default_nettype none
module sfp_out_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire sfp_pkg::res_t res,
    output logic               slot_free,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [sfp_pkg::PayloadLen*sfp_pkg::ByteW-1:0] m_tdata,
    output logic               m_tuser
);

    logic                                       valid_reg;
    logic [sfp_pkg::PayloadLen*sfp_pkg::ByteW-1:0] data_reg;
    logic                                       ok_reg;

    assign slot_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= load && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && load && res.emit) begin
            data_reg <= res.payload;
            ok_reg   <= res.frame_ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = ok_reg;

endmodule
`default_nettype wire

FILE: sv/sync_framed_packet_parser_top.sv
// Top level of the sync framed packet parser: config registers, deframer
// and result register. Depends on sfp_pkg, sfp_deframer and sfp_out_reg.
//
// Bytes enter on the s_ stream, one item per byte. A frame is two header
// bytes, nine payload bytes and two trailer bytes. At the last trailer
// byte, or at a bad first trailer byte, one result item leaves on the m_
// stream: m_tuser is frame_ok and m_tdata the nine payload bytes (all zero
// when the frame is rejected). Header mismatches give no item.
// One byte is taken every cycle while s_tready is high. A result appears
// on m_ in the cycle after the trailer byte that closes the frame is
// accepted; it waits in the result register. When the receiver stalls with
// a result held, s_tready drops until the result is taken. The config port
// writes header and trailer values; write it only while the stream is idle.
// Reset (aresetn low at a clock edge) returns the parser to header hunt,
// empties the result register and loads the default register values.
`default_nettype none
module sync_framed_packet_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte [7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // payload_0 [7:0] .. payload_8 [71:64]
    output logic             m_tuser,   // frame_ok [0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    sfp_pkg::cfg_t cfg_reg;
    sfp_pkg::res_t res;
    logic          slot_free;
    logic          accept;

    assign s_tready = slot_free;
    assign accept   = s_tvalid && slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte     <= sfp_pkg::HEADER_RST;
            cfg_reg.first_tail_byte <= sfp_pkg::TAIL1_RST;
            cfg_reg.last_tail_byte  <= sfp_pkg::TAIL2_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sfp_pkg::CFG_HEADER: cfg_reg.header_byte     <= cfg_data;
                sfp_pkg::CFG_TAIL1:  cfg_reg.first_tail_byte <= cfg_data;
                sfp_pkg::CFG_TAIL2:  cfg_reg.last_tail_byte  <= cfg_data;
                default: ;
            endcase
        end
    end

    sfp_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .res     (res)
    );

    sfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
